// ----- src/shortest_remaining_time_scheduler_assert.svh -----
// Assertion macros for the scheduler RTL.
// SRTF_ASSERT checks a property outside of reset.
// SRTF_ASSERT_ALWAYS checks a property at every edge, reset included.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define SRTF_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scheduler check failed");
`define SRTF_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("scheduler check failed");
`else
`define SRTF_ASSERT(name, prop)
`define SRTF_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ----- src/srtf_pkg.sv -----
package srtf_pkg;

  // Parameter defaults
  localparam int MAX_TASKS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 16;

  // Fixed field widths of the ports
  localparam int STATUS_W = 2;
  localparam int ID_W     = 5;
  localparam int FIELD_W  = 16;

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RAN      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

  // Control from the sequencer to the pick unit
  typedef struct packed {
    logic clear;  // start a new scan
    logic load;   // a table entry is on the read data this cycle
  } pick_ctrl_t;

endpackage

// ----- src/srtf_ram.sv -----
module srtf_ram
  import srtf_pkg::*;
#(
  parameter int WIDTH = 3 * TIME_WIDTH_DEF,
  parameter int DEPTH = MAX_TASKS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/srtf_pick.sv -----
module srtf_pick
  import srtf_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int IDX_W      = $clog2(MAX_TASKS_DEF)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pick_ctrl_t            ctrl,
  input  logic [IDX_W-1:0]      entry_idx,
  input  logic [TIME_WIDTH-1:0] entry_arr,
  input  logic [TIME_WIDTH-1:0] entry_burst,
  input  logic [TIME_WIDTH-1:0] entry_rem,
  input  logic [TIME_WIDTH-1:0] clock_value,
  output logic                  found,
  output logic [IDX_W-1:0]      best_idx,
  output logic [TIME_WIDTH-1:0] best_arr,
  output logic [TIME_WIDTH-1:0] best_burst,
  output logic [TIME_WIDTH-1:0] best_rem
);

  logic eligible;
  logic better;

  // Arrived and unfinished; strict less-than keeps the earliest on a tie
  assign eligible = (entry_arr <= clock_value) && (entry_rem != '0);
  assign better   = eligible && (!found || (entry_rem < best_rem));

  // Track whether any candidate has been seen
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (ctrl.load && better) begin
      found <= 1'b1;
    end
  end

  // Hold the best entry so far
  always_ff @(posedge clk) begin
    if (ctrl.load && better) begin
      best_idx   <= entry_idx;
      best_arr   <= entry_arr;
      best_burst <= entry_burst;
      best_rem   <= entry_rem;
    end
  end

endmodule

// ----- src/shortest_remaining_time_scheduler.sv -----
// Channel   Handshake                    Payload
// item      item_valid / item_ready      opcode, arrival_time, burst_time
// result    result_valid / result_ready  status, task_id, finished, completion_time,
//                                        turnaround, waiting, all_done, clock_now
//
// A load transaction goes through the load and emit steps before the next acceptance.
// A tick transaction goes through the scan, pick and emit steps; the task RAM has one
// read port, so the scan reads one table entry per cycle.
// Reset is synchronous and clears counters and clock; the RAM is not cleared,
// only entries below the load count are read.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits in the last step until the register frees.
module shortest_remaining_time_scheduler
  import srtf_pkg::*;
#(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                opcode,
  input  logic [FIELD_W-1:0]  arrival_time,
  input  logic [FIELD_W-1:0]  burst_time,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ID_W-1:0]     task_id,
  output logic                finished,
  output logic [FIELD_W-1:0]  completion_time,
  output logic [FIELD_W-1:0]  turnaround,
  output logic [FIELD_W-1:0]  waiting,
  output logic                all_done,
  output logic [FIELD_W-1:0]  clock_now
);

`include "shortest_remaining_time_scheduler_assert.svh"

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ENT_W = 3 * TIME_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]            state;
  logic [TIME_WIDTH-1:0] at_r;
  logic [TIME_WIDTH-1:0] bt_r;
  logic [CNT_W-1:0]      loaded_count;
  logic [CNT_W-1:0]      done_count;
  logic [TIME_WIDTH-1:0] clock_value;
  logic [CNT_W-1:0]      scan_idx;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;

  // Pending result
  logic [STATUS_W-1:0]   res_status;
  logic [ID_W-1:0]       res_id;
  logic                  res_fin;
  logic [FIELD_W-1:0]    res_ct;
  logic [FIELD_W-1:0]    res_tat;
  logic [FIELD_W-1:0]    res_wt;
  logic                  res_all;
  logic [FIELD_W-1:0]    res_clk;

  logic                  accept;
  logic                  issue;
  logic                  load_ok;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;

  pick_ctrl_t            pick_ctrl;
  logic                  found;
  logic [IDX_W-1:0]      best_idx;
  logic [TIME_WIDTH-1:0] best_arr;
  logic [TIME_WIDTH-1:0] best_burst;
  logic [TIME_WIDTH-1:0] best_rem;

  logic [TIME_WIDTH-1:0] clock_inc;
  logic [TIME_WIDTH-1:0] rem_dec;
  logic [TIME_WIDTH-1:0] tat_val;
  logic [TIME_WIDTH-1:0] wt_val;
  logic                  task_fin;
  logic [CNT_W-1:0]      done_next;
  logic [CNT_W-1:0]      loaded_next;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  // Scan read: one entry per cycle while below the load count
  assign issue     = (state == S_SCAN) && (scan_idx < loaded_count);
  assign ram_re    = issue;
  assign ram_raddr = scan_idx[IDX_W-1:0];

  // Load check: room in the table and nonzero burst
  assign load_ok     = (loaded_count < CNT_W'(MAX_TASKS)) && (bt_r != '0);
  assign loaded_next = loaded_count + CNT_W'(1);

  // Tick arithmetic on the picked task
  assign clock_inc = (clock_value == {TIME_WIDTH{1'b1}}) ? clock_value
                                                         : clock_value + 1'b1;
  assign rem_dec   = best_rem - 1'b1;
  assign task_fin  = found && (rem_dec == '0);
  assign tat_val   = clock_inc - best_arr;
  assign wt_val    = (tat_val >= best_burst) ? (tat_val - best_burst) : '0;
  assign done_next = done_count + CNT_W'(task_fin);

  // RAM write: new task on load, decremented remaining time on tick
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = {best_arr, best_burst, rem_dec};
    if (state == S_LOAD) begin
      ram_we    = load_ok;
      ram_waddr = loaded_count[IDX_W-1:0];
      ram_wdata = {at_r, bt_r, bt_r};
    end else if (state == S_PICK) begin
      ram_we = found;
    end
  end

  assign pick_ctrl.clear = accept;
  assign pick_ctrl.load  = rd_vld;

  srtf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srtf_pick #(
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IDX_W)
  ) u_pick (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (pick_ctrl),
    .entry_idx   (rd_idx),
    .entry_arr   (ram_rdata[ENT_W-1 -: TIME_WIDTH]),
    .entry_burst (ram_rdata[2*TIME_WIDTH-1 -: TIME_WIDTH]),
    .entry_rem   (ram_rdata[TIME_WIDTH-1:0]),
    .clock_value (clock_value),
    .found       (found),
    .best_idx    (best_idx),
    .best_arr    (best_arr),
    .best_burst  (best_burst),
    .best_rem    (best_rem)
  );

  // Sequencer and architectural counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      done_count   <= '0;
      clock_value  <= '0;
      scan_idx     <= '0;
      rd_vld       <= 1'b0;
    end else begin
      rd_vld <= issue;
      rd_idx <= ram_raddr;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            scan_idx <= '0;
            state    <= (opcode == OP_LOAD) ? S_LOAD : S_SCAN;
          end
        end
        S_LOAD: begin
          if (load_ok) begin
            loaded_count <= loaded_next;
          end
          state <= S_EMIT;
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          clock_value <= clock_inc;
          done_count  <= done_next;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      at_r <= TIME_WIDTH'(arrival_time);
      bt_r <= TIME_WIDTH'(burst_time);
    end
  end

  // Build the pending result
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      res_status <= load_ok ? ST_LOADED : ST_REJECTED;
      res_id     <= load_ok ? ID_W'(loaded_next) : '0;
      res_fin    <= 1'b0;
      res_ct     <= '0;
      res_tat    <= '0;
      res_wt     <= '0;
      res_all    <= load_ok ? (done_count == loaded_next) : (done_count == loaded_count);
      res_clk    <= FIELD_W'(clock_value);
    end else if (state == S_PICK) begin
      res_status <= found ? ST_RAN : ST_IDLE;
      res_id     <= found ? ID_W'(CNT_W'(best_idx) + CNT_W'(1)) : '0;
      res_fin    <= task_fin;
      res_ct     <= task_fin ? FIELD_W'(clock_inc) : '0;
      res_tat    <= task_fin ? FIELD_W'(tat_val) : '0;
      res_wt     <= task_fin ? FIELD_W'(wt_val) : '0;
      res_all    <= (done_next == loaded_count);
      res_clk    <= FIELD_W'(clock_inc);
    end
  end

  // Output register: hold until the result transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_EMIT) && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!result_valid || result_ready)) begin
      status          <= res_status;
      task_id         <= res_id;
      finished        <= res_fin;
      completion_time <= res_ct;
      turnaround      <= res_tat;
      waiting         <= res_wt;
      all_done        <= res_all;
      clock_now       <= res_clk;
    end
  end

  `SRTF_ASSERT(a_count_order, (done_count <= loaded_count) && (loaded_count <= CNT_W'(MAX_TASKS)))
  `SRTF_ASSERT(a_no_ram_collision, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
  `SRTF_ASSERT(a_scan_complete, (state == S_PICK) |-> ((scan_idx == loaded_count) && !rd_vld))
  `SRTF_ASSERT(a_idle_no_task, (result_valid && (status == ST_IDLE)) |-> ((task_id == '0) && !finished))
  `SRTF_ASSERT_ALWAYS(a_reset_clears, rst |=> ((state == S_IDLE) && !result_valid))

endmodule

// ----- tb/sv/shortest_remaining_time_scheduler_tb.sv -----
module shortest_remaining_time_scheduler_tb;
  import srtf_pkg::*;

  localparam int TASK_SLOTS = MAX_TASKS_DEF;
  localparam int IDLE_PCT = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int RANDOM_TASK_CAP = 9;
  localparam int TAIL_ITEMS = 100;
  localparam logic [FIELD_W-1:0] CLOCK_TOP = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     task_id;
    logic                finished;
    logic [FIELD_W-1:0]  completion_time;
    logic [FIELD_W-1:0]  turnaround;
    logic [FIELD_W-1:0]  waiting;
    logic                all_done;
    logic [FIELD_W-1:0]  clock_now;
  } sched_outcome_t;

  // Mirror of the task table; predicts one outcome per transaction
  class schedule_scoreboard;
    logic [FIELD_W-1:0] arrival_tab [TASK_SLOTS];
    logic [FIELD_W-1:0] burst_tab [TASK_SLOTS];
    logic [FIELD_W-1:0] left_tab [TASK_SLOTS];
    int unsigned loaded = 0;
    int unsigned done = 0;
    logic [FIELD_W-1:0] sched_clock = '0;
    sched_outcome_t outcome_q[$];
    int unsigned errors = 0;
    int unsigned loads = 0;
    int unsigned rejects = 0;
    int unsigned runs = 0;
    int unsigned idles = 0;
    int unsigned completions = 0;
    int unsigned clamped = 0;

    function void note_item(logic op, logic [FIELD_W-1:0] arr, logic [FIELD_W-1:0] brst);
      sched_outcome_t o;
      int pick;
      bit found;
      logic [FIELD_W-1:0] tat;
      o = '0;
      if (op == OP_LOAD) begin
        // Reject on a full table or an empty burst, else append
        if (loaded >= TASK_SLOTS || brst == '0) begin
          o.status = ST_REJECTED;
          rejects++;
        end else begin
          arrival_tab[loaded] = arr;
          burst_tab[loaded] = brst;
          left_tab[loaded] = brst;
          loaded++;
          o.status = ST_LOADED;
          o.task_id = ID_W'(loaded);
          loads++;
        end
      end else begin
        // Pick the arrived task with least work left; strict compare keeps ties early
        found = 1'b0;
        pick = 0;
        for (int i = 0; i < loaded; i++) begin
          if (arrival_tab[i] <= sched_clock && left_tab[i] != '0) begin
            if (!found || left_tab[i] < left_tab[pick]) begin
              pick = i;
              found = 1'b1;
            end
          end
        end
        // Advance the clock, holding at its ceiling
        if (sched_clock != CLOCK_TOP) sched_clock++;
        if (!found) begin
          o.status = ST_IDLE;
          idles++;
        end else begin
          left_tab[pick]--;
          o.status = ST_RAN;
          o.task_id = ID_W'(pick + 1);
          runs++;
          if (left_tab[pick] == '0) begin
            done++;
            completions++;
            tat = sched_clock - arrival_tab[pick];
            o.finished = 1'b1;
            o.completion_time = sched_clock;
            o.turnaround = tat;
            if (tat >= burst_tab[pick]) begin
              o.waiting = tat - burst_tab[pick];
            end else begin
              o.waiting = '0;
              clamped++;
            end
          end
        end
      end
      o.all_done = (done == loaded);
      o.clock_now = sched_clock;
      outcome_q.insert(outcome_q.size(), o);
    endfunction

    function void compare_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(sched_outcome_t got);
      sched_outcome_t want;
      if (outcome_q.size() == 0) begin
        $error("result with no transaction pending: status %0d task_id %0d",
               got.status, got.task_id);
        errors++;
        return;
      end
      want = outcome_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("task_id", want.task_id, got.task_id);
      compare_field("finished", want.finished, got.finished);
      compare_field("completion_time", want.completion_time, got.completion_time);
      compare_field("turnaround", want.turnaround, got.turnaround);
      compare_field("waiting", want.waiting, got.waiting);
      compare_field("all_done", want.all_done, got.all_done);
      compare_field("clock_now", want.clock_now, got.clock_now);
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic                opcode = OP_LOAD;
  logic [FIELD_W-1:0]  arrival_time = '0;
  logic [FIELD_W-1:0]  burst_time = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     task_id;
  logic                finished;
  logic [FIELD_W-1:0]  completion_time;
  logic [FIELD_W-1:0]  turnaround;
  logic [FIELD_W-1:0]  waiting;
  logic                all_done;
  logic [FIELD_W-1:0]  clock_now;

  schedule_scoreboard sched = new;
  sched_outcome_t observed;
  bit no_idle = 1'b0;

  shortest_remaining_time_scheduler dut (.*);

  assign observed = {status, task_id, finished, completion_time, turnaround, waiting,
                     all_done, clock_now};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    return !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Stall the result side at random
  always @(negedge clk) begin
    result_ready <= !take_break();
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sched.check_outcome(observed);
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Present one item, hold it until taken, then note it
  task automatic send_item(logic op, logic [FIELD_W-1:0] arr, logic [FIELD_W-1:0] brst);
    while (take_break()) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    opcode       <= op;
    arrival_time <= arr;
    burst_time   <= brst;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sched.note_item(op, arr, brst);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  // Hold off the sender until every outcome is back
  task automatic wait_for_drain();
    item_valid <= 1'b0;
    do @(negedge clk); while (sched.outcome_q.size() != 0);
  endtask

  initial begin : stimulus
    logic [FIELD_W-1:0] arr;
    logic [FIELD_W-1:0] brst;
    int unsigned roll;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: idle tick, then a rejected empty burst
    send_item(OP_TICK, CLOCK_TOP, CLOCK_TOP);
    send_item(OP_LOAD, '0, '0);
    // Staggered arrivals; the fourth task ties the first on work left
    send_item(OP_LOAD, 16'd3, 16'd4);
    send_tick();
    send_item(OP_LOAD, 16'd0, 16'd1);
    send_item(OP_LOAD, 16'd1, 16'd3);
    send_item(OP_LOAD, 16'd5, 16'd4);
    repeat (14) send_tick();
    send_item(OP_LOAD, CLOCK_TOP, '0);
    repeat (2) send_tick();

    // Mostly ticks with sparse task loads and a few empty bursts
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 300 && n < 700);
      roll = $urandom_range(0, 99);
      if (roll < 2 && sched.loaded < RANDOM_TASK_CAP) begin
        if ($urandom_range(0, 9) == 0) arr = FIELD_W'($urandom);
        else arr = sched.sched_clock + FIELD_W'($urandom_range(0, 100));
        if ($urandom_range(0, 5) == 0) brst = FIELD_W'($urandom_range(1, 65535));
        else brst = FIELD_W'($urandom_range(1, 8) * $urandom_range(1, 16));
        send_item(OP_LOAD, arr, brst);
      end else if (roll < 5) begin
        send_item(OP_LOAD, FIELD_W'($urandom), '0);
      end else begin
        send_tick();
      end
    end
    no_idle = 1'b0;

    // Drain before the final phase
    wait_for_drain();

    // Far and early arrivals, then fill the table and keep ticking past full
    send_item(OP_LOAD, CLOCK_TOP, 16'd1);
    send_item(OP_LOAD, '0, CLOCK_TOP);
    send_item(OP_LOAD, 16'hFFF0, 16'd40);
    while (sched.loaded < TASK_SLOTS) begin
      send_item(OP_LOAD, FIELD_W'($urandom), FIELD_W'($urandom_range(1, 6)));
    end
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) send_item(OP_LOAD, FIELD_W'($urandom), FIELD_W'($urandom));
      else if (roll == 1) send_item(OP_LOAD, FIELD_W'($urandom), '0);
      else send_tick();
    end

    wait_for_drain();
    repeat (40) @(negedge clk);

    $display("checked %0d transactions: %0d loads taken, %0d rejected, %0d ran, %0d idle",
             sched.loads + sched.rejects + sched.runs + sched.idles, sched.loads,
             sched.rejects, sched.runs, sched.idles);
    $display("%0d tasks finished (%0d with waiting clamped), clock ended at %0d",
             sched.completions, sched.clamped, sched.sched_clock);
    if (sched.errors == 0 && sched.outcome_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/srtf_pkg.sv
src/srtf_ram.sv
src/srtf_pick.sv
src/shortest_remaining_time_scheduler.sv
tb/sv/shortest_remaining_time_scheduler_tb.sv
